>>> src/dmc_pkg.sv
package dmc_pkg;

  localparam int MaxRows    = 64;
  localparam int MaxCols    = 64;
  localparam int StackDepth = 1024;
  localparam int RowW       = $clog2(MaxRows);
  localparam int ColW       = $clog2(MaxCols);
  localparam int PosW       = RowW + ColW;
  localparam int GridCells  = MaxRows * MaxCols;
  localparam int SpW        = $clog2(StackDepth);
  localparam int CntW       = SpW + 1;
  localparam int CfgW       = 7;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgGridRows = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgGridCols = 1'd1;

  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdStep  = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [2:0] EvStarted  = 3'd0;
  localparam logic [2:0] EvCarved   = 3'd1;
  localparam logic [2:0] EvBack     = 3'd2;
  localparam logic [2:0] EvFinished = 3'd3;
  localparam logic [2:0] EvRead     = 3'd4;
  localparam logic [2:0] EvRejected = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row_in;
    logic [5:0] col_in;
    logic [1:0] choice;
  } req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [5:0] cur_row;
    logic [5:0] cur_col;
    logic       cell_open;
  } res_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StRdWait,
    StProbe,
    StProbeWait,
    StDecide,
    StCarve2,
    StPopWait,
    StOut
  } state_e;

endpackage

>>> src/dmc_grid_ram.sv
module dmc_grid_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [dmc_pkg::PosW-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic [dmc_pkg::PosW-1:0] raddr_i,
  output logic                     rdata_o
);

  logic mem [dmc_pkg::GridCells];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/dmc_stack_ram.sv
module dmc_stack_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [dmc_pkg::SpW-1:0]  waddr_i,
  input  logic [dmc_pkg::PosW-1:0] wdata_i,
  input  logic [dmc_pkg::SpW-1:0]  raddr_i,
  output logic [dmc_pkg::PosW-1:0] rdata_o
);

  logic [dmc_pkg::PosW-1:0] mem [dmc_pkg::StackDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/dfs_maze_carver.sv
// dfs_maze_carver: randomized depth-first maze carving over a 64x64 grid of wall bits
// request channel: req_valid_i / req_stall_o / req_i (cmd, row_in, col_in, choice)
//   cmd start opens a cell and seeds the walk, step moves the walker once,
//   read returns one grid bit
// result channel: res_valid_o / res_stall_i / res_o, exactly one result per request
// configuration: cfg_we_i writes grid_rows (index 0) or grid_cols (index 1); write
//   only when idle, the block itself does not enforce it
// operation: a rejected request or a step on an empty stack loads the result
//   register on the edge that takes it, a read waits on one grid read, any other
//   step makes eight grid reads through the single read port of the grid memory
//   and then decides and carves, or pops and reads the stack, and a start first
//   sweeps every grid entry to wall; one request is handled at a time, the next
//   is taken the cycle after the result leaves the output register
// reset: after reset a clearing pass over all 4096 entries sets the grid to walls,
//   no request is taken during it; stack empty, walker at row 0 column 0,
//   grid_rows and grid_cols 63
// a stalled result holds in the output register; the block waits until it is taken
module dfs_maze_carver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_stall_o,
  input  dmc_pkg::req_t               req_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output dmc_pkg::res_t               res_o,
  input  logic                        cfg_we_i,
  input  logic [dmc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dmc_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int PosW = dmc_pkg::PosW;
  localparam int RowW = dmc_pkg::RowW;
  localparam int ColW = dmc_pkg::ColW;

  dmc_pkg::state_e state_q, state_d;
  logic [dmc_pkg::CfgW-1:0] rows_q, cols_q;
  logic [PosW-1:0] clr_q, clr_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [dmc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [2:0] pidx_q, pidx_d;
  logic [7:0] bits_q, bits_d;
  logic [1:0] choice_q, choice_d;
  logic [1:0] dir_q, dir_d;
  logic start_q, start_d;
  logic res_valid_q, res_valid_d;
  dmc_pkg::res_t res_q, res_d;

  logic g_we, g_wd, g_rd;
  logic [PosW-1:0] g_wa, g_ra;
  logic s_we;
  logic [dmc_pkg::SpW-1:0] s_wa, s_ra;
  logic [PosW-1:0] s_wd, s_rd;

  dmc_grid_ram u_grid (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd)
  );
  dmc_stack_ram u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  logic [7:0] rows_e, cols_e;
  assign rows_e = (rows_q > 7'(dmc_pkg::MaxRows)) ? 8'(dmc_pkg::MaxRows) : 8'(rows_q);
  assign cols_e = (cols_q > 7'(dmc_pkg::MaxCols)) ? 8'(dmc_pkg::MaxCols) : 8'(cols_q);

  logic [RowW-1:0] cr;
  logic [ColW-1:0] cc;
  assign cr = pos_q[PosW-1:ColW];
  assign cc = pos_q[ColW-1:0];

  // neighbour k: target and the wall in between, with signed 9 bit coordinates
  logic signed [8:0] nr [4], nc [4], wr [4], wc [4];
  logic [3:0] inr;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nr[k] = $signed({3'b0, cr});
      nc[k] = $signed({3'b0, cc});
      unique case (2'(k))
        2'd0: nr[k] = nr[k] - 9'sd2;
        2'd1: nr[k] = nr[k] + 9'sd2;
        2'd2: nc[k] = nc[k] - 9'sd2;
        default: nc[k] = nc[k] + 9'sd2;
      endcase
      wr[k] = ($signed({3'b0, cr}) + nr[k]) >>> 1;
      wc[k] = ($signed({3'b0, cc}) + nc[k]) >>> 1;
      inr[k] = (nr[k] > 9'sd0) && (nr[k] < $signed({1'b0, rows_e}) - 9'sd1) &&
               (nc[k] > 9'sd0) && (nc[k] < $signed({1'b0, cols_e}) - 9'sd1);
    end
  end

  // probe address: even index target, odd index wall
  logic [PosW-1:0] paddr;
  logic [1:0] pk;
  always_comb begin
    pk = pidx_q[2:1];
    if (pidx_q[0]) begin
      paddr = {wr[pk][RowW-1:0], wc[pk][ColW-1:0]};
    end else begin
      paddr = {nr[pk][RowW-1:0], nc[pk][ColW-1:0]};
    end
  end

  logic [3:0] elig;
  logic [2:0] ncnt;
  logic [1:0] sel, cand0, cand1, cand2, cand3, pick;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      elig[k] = inr[k] && bits_q[2*k] && bits_q[2*k+1];
    end
    ncnt = 3'(elig[0]) + 3'(elig[1]) + 3'(elig[2]) + 3'(elig[3]);
    cand0 = 2'd0; cand1 = 2'd0; cand2 = 2'd0; cand3 = 2'd0;
    sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (elig[k]) begin
        cand3 = cand2; cand2 = cand1; cand1 = cand0; cand0 = 2'(k);
      end
    end
    unique case (ncnt)
      3'd3: sel = (choice_q == 2'd3) ? 2'd0 : choice_q;
      3'd2: sel = {1'b0, choice_q[0]};
      3'd4: sel = choice_q;
      default: sel = 2'd0;
    endcase
    unique case (sel)
      2'd0: pick = cand0;
      2'd1: pick = cand1;
      2'd2: pick = cand2;
      default: pick = cand3;
    endcase
  end

  logic [PosW-1:0] tgt;
  assign tgt  = {nr[dir_q][RowW-1:0], nc[dir_q][ColW-1:0]};

  logic req_fire;
  assign req_stall_o = !(state_q == dmc_pkg::StIdle) || res_valid_q;
  assign req_fire = req_valid_i && !req_stall_o;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  function automatic dmc_pkg::res_t mk(logic [2:0] ev, logic [PosW-1:0] p, logic o);
    dmc_pkg::res_t r;
    r.event_res = ev;
    r.cur_row = p[PosW-1:ColW];
    r.cur_col = p[ColW-1:0];
    r.cell_open = o;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    pidx_d = pidx_q;
    bits_d = bits_q;
    choice_d = choice_q;
    dir_d = dir_q;
    start_d = start_q;
    res_valid_d = res_valid_q && res_stall_i;
    res_d = res_q;
    g_we = 1'b0; g_wa = clr_q; g_wd = 1'b1; g_ra = paddr;
    s_we = 1'b0; s_wa = cnt_q[dmc_pkg::SpW-1:0]; s_wd = pos_q;
    // top entry after the pop, read while waiting on the stack memory
    s_ra = dmc_pkg::SpW'(cnt_q - dmc_pkg::CntW'(1));
    unique case (state_q)
      dmc_pkg::StIdle: begin
        if (req_fire) begin
          choice_d = req_i.choice;
          unique case (req_i.cmd)
            dmc_pkg::CmdStart: begin
              if ({2'b0, req_i.row_in} >= rows_e || {2'b0, req_i.col_in} >= cols_e) begin
                res_d = mk(dmc_pkg::EvRejected, pos_q, 1'b0);
                res_valid_d = 1'b1;
              end else begin
                pos_d = {req_i.row_in, req_i.col_in};
                clr_d = '0;
                start_d = 1'b1;
                state_d = dmc_pkg::StClear;
              end
            end
            dmc_pkg::CmdStep: begin
              if (cnt_q == '0) begin
                res_d = mk(dmc_pkg::EvFinished, pos_q, 1'b0);
                res_valid_d = 1'b1;
              end else begin
                pidx_d = '0;
                state_d = dmc_pkg::StProbe;
              end
            end
            dmc_pkg::CmdRead: begin
              g_ra = {req_i.row_in, req_i.col_in};
              state_d = dmc_pkg::StRdWait;
            end
            default: begin
              res_d = mk(dmc_pkg::EvRejected, pos_q, 1'b0);
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      dmc_pkg::StClear: begin
        g_we = 1'b1;
        g_wa = clr_q;
        g_wd = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          if (start_q) begin
            g_wd = !(clr_q == pos_q);
            state_d = dmc_pkg::StCarve2;
          end else begin
            state_d = dmc_pkg::StIdle;
          end
        end
      end
      dmc_pkg::StRdWait: begin
        res_d = mk(dmc_pkg::EvRead, pos_q, !g_rd);
        res_valid_d = 1'b1;
        state_d = dmc_pkg::StIdle;
      end
      dmc_pkg::StProbe: begin
        g_ra = paddr;
        state_d = dmc_pkg::StProbeWait;
      end
      dmc_pkg::StProbeWait: begin
        bits_d[pidx_q] = g_rd;
        if (pidx_q == 3'd7) begin
          state_d = dmc_pkg::StDecide;
        end else begin
          pidx_d = pidx_q + 1'b1;
          state_d = dmc_pkg::StProbe;
        end
      end
      dmc_pkg::StDecide: begin
        if (ncnt != '0) begin
          if (cnt_q >= dmc_pkg::CntW'(dmc_pkg::StackDepth)) begin
            res_d = mk(dmc_pkg::EvRejected, pos_q, 1'b0);
            res_valid_d = 1'b1;
            state_d = dmc_pkg::StIdle;
          end else begin
            dir_d = pick;
            start_d = 1'b0;
            g_we = 1'b1;
            g_wa = {wr[pick][RowW-1:0], wc[pick][ColW-1:0]};
            g_wd = 1'b0;
            state_d = dmc_pkg::StCarve2;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == dmc_pkg::CntW'(1)) begin
            res_d = mk(dmc_pkg::EvFinished, pos_q, 1'b0);
            res_valid_d = 1'b1;
            state_d = dmc_pkg::StIdle;
          end else begin
            state_d = dmc_pkg::StPopWait;
          end
        end
      end
      dmc_pkg::StCarve2: begin
        if (start_q) begin
          // start: open cell and seed the stack
          g_we = 1'b1; g_wa = pos_q; g_wd = 1'b0;
          s_we = 1'b1; s_wa = '0; s_wd = pos_q;
          cnt_d = dmc_pkg::CntW'(1);
          start_d = 1'b0;
          res_d = mk(dmc_pkg::EvStarted, pos_q, 1'b0);
        end else begin
          g_we = 1'b1; g_wa = tgt; g_wd = 1'b0;
          s_we = 1'b1; s_wa = cnt_q[dmc_pkg::SpW-1:0]; s_wd = tgt;
          cnt_d = cnt_q + 1'b1;
          pos_d = tgt;
          res_d = mk(dmc_pkg::EvCarved, tgt, 1'b0);
        end
        res_valid_d = 1'b1;
        state_d = dmc_pkg::StIdle;
      end
      dmc_pkg::StPopWait: begin
        state_d = dmc_pkg::StOut;
      end
      dmc_pkg::StOut: begin
        pos_d = s_rd;
        res_d = mk(dmc_pkg::EvBack, s_rd, 1'b0);
        res_valid_d = 1'b1;
        state_d = dmc_pkg::StIdle;
      end
      default: state_d = dmc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmc_pkg::StClear;
      clr_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      start_q <= 1'b0;
      res_valid_q <= 1'b0;
      rows_q <= 7'd63;
      cols_q <= 7'd63;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      start_q <= start_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dmc_pkg::CfgGridRows: rows_q <= cfg_data_i;
          default: cols_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    bits_q <= bits_d;
    choice_q <= choice_d;
    dir_q <= dir_d;
    res_q <= res_d;
  end

endmodule

>>> src/dmc_checker.sv
module dmc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_stall_o,
  input logic          res_valid_o,
  input logic          res_stall_i,
  input dmc_pkg::res_t res_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> req_stall_o)
    else $error("request taken while result pending");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.event_res <= dmc_pkg::EvRejected)
    else $error("bad event code");

  a_open_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.cell_open |-> res_o.event_res == dmc_pkg::EvRead)
    else $error("cell_open outside read reply");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (
  .clk_i, .rst_ni, .req_stall_o, .res_valid_o, .res_stall_i, .res_o
);

>>> sim/tb_dfs_maze_carver.sv
module tb_dfs_maze_carver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int IdlePct = 22;
  localparam int WatchLimit = 20000;
  localparam int TargetItems = 1250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  dmc_pkg::req_t req_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  dmc_pkg::res_t res_o;
  logic cfg_we_i = 1'b0;
  logic [dmc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [dmc_pkg::CfgW-1:0] cfg_data_i = '0;

  dfs_maze_carver DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // walker state mirror
  bit wall_bits [dmc_pkg::GridCells];
  logic [dmc_pkg::PosW-1:0] path_stack [dmc_pkg::StackDepth];
  int path_depth;
  int walk_row, walk_col;
  int rows_cfg, cols_cfg;

  dmc_pkg::res_t result_q[$];
  int n_accepted;
  int n_mismatch;
  int hold_left;
  int stall_cycles;
  bit hold_done;

  function automatic bit quiet_now();
    return n_accepted >= 300 && n_accepted < 500;
  endfunction

  function automatic int rows_eff();
    return rows_cfg > dmc_pkg::MaxRows ? dmc_pkg::MaxRows : rows_cfg;
  endfunction

  function automatic int cols_eff();
    return cols_cfg > dmc_pkg::MaxCols ? dmc_pkg::MaxCols : cols_cfg;
  endfunction

  function automatic bit can_carve(int r, int c, int nr, int nc);
    if (nr <= 0 || nr >= rows_eff() - 1 || nc <= 0 || nc >= cols_eff() - 1) return 1'b0;
    if (!wall_bits[nr * dmc_pkg::MaxCols + nc]) return 1'b0;
    return wall_bits[((r + nr) / 2) * dmc_pkg::MaxCols + (c + nc) / 2];
  endfunction

  function automatic dmc_pkg::res_t walk_predict(dmc_pkg::req_t rq);
    dmc_pkg::res_t o;
    int dr [4];
    int dc [4];
    int cand [4];
    int n, d, nr, nc;
    dr = '{-2, 2, 0, 0};
    dc = '{0, 0, -2, 2};
    o = '0;
    n = 0;
    case (rq.cmd)
      dmc_pkg::CmdStart: begin
        if (rq.row_in >= rows_eff() || rq.col_in >= cols_eff()) begin
          o.event_res = dmc_pkg::EvRejected;
        end else begin
          foreach (wall_bits[i]) wall_bits[i] = 1'b1;
          walk_row = rq.row_in;
          walk_col = rq.col_in;
          wall_bits[walk_row * dmc_pkg::MaxCols + walk_col] = 1'b0;
          path_stack[0] = dmc_pkg::PosW'(walk_row * dmc_pkg::MaxCols + walk_col);
          path_depth = 1;
          o.event_res = dmc_pkg::EvStarted;
        end
      end
      dmc_pkg::CmdStep: begin
        if (path_depth == 0) begin
          o.event_res = dmc_pkg::EvFinished;
        end else begin
          for (int k = 0; k < 4; k++)
            if (can_carve(walk_row, walk_col, walk_row + dr[k], walk_col + dc[k])) begin
              cand[n] = k;
              n++;
            end
          if (n > 0) begin
            d = cand[rq.choice % n];
            nr = walk_row + dr[d];
            nc = walk_col + dc[d];
            if (path_depth >= dmc_pkg::StackDepth) begin
              o.event_res = dmc_pkg::EvRejected;
            end else begin
              wall_bits[nr * dmc_pkg::MaxCols + nc] = 1'b0;
              wall_bits[((walk_row + nr) / 2) * dmc_pkg::MaxCols + (walk_col + nc) / 2] = 1'b0;
              walk_row = nr;
              walk_col = nc;
              path_stack[path_depth] = dmc_pkg::PosW'(nr * dmc_pkg::MaxCols + nc);
              path_depth++;
              o.event_res = dmc_pkg::EvCarved;
            end
          end else begin
            path_depth--;
            if (path_depth == 0) begin
              o.event_res = dmc_pkg::EvFinished;
            end else begin
              walk_row = path_stack[path_depth - 1] / dmc_pkg::MaxCols;
              walk_col = path_stack[path_depth - 1] % dmc_pkg::MaxCols;
              o.event_res = dmc_pkg::EvBack;
            end
          end
        end
      end
      dmc_pkg::CmdRead: begin
        o.event_res = dmc_pkg::EvRead;
        o.cell_open = !wall_bits[rq.row_in * dmc_pkg::MaxCols + rq.col_in];
      end
      default: o.event_res = dmc_pkg::EvRejected;
    endcase
    o.cur_row = 6'(walk_row);
    o.cur_col = 6'(walk_col);
    return o;
  endfunction

  task automatic send_req(dmc_pkg::req_t rq, bit typed, dmc_pkg::res_t typed_res);
    dmc_pkg::res_t p;
    @(negedge clk_i);
    while (!quiet_now() && $urandom_range(99) < IdlePct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (req_stall_o);
    p = walk_predict(rq);
    result_q.insert(result_q.size(), typed ? typed_res : p);
    n_accepted++;
  endtask

  task automatic write_cfg(logic [dmc_pkg::CfgIdxW-1:0] idx, int val);
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= dmc_pkg::CfgW'(val);
    if (idx == dmc_pkg::CfgGridRows) rows_cfg = val;
    else cols_cfg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    wait (result_q.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic dmc_pkg::req_t mk(logic [1:0] cmd, int r, int c, int ch);
    dmc_pkg::req_t rq;
    rq.cmd = cmd;
    rq.row_in = 6'(r);
    rq.col_in = 6'(c);
    rq.choice = 2'(ch);
    return rq;
  endfunction

  function automatic dmc_pkg::res_t mr(logic [2:0] ev, int r, int c, bit op);
    dmc_pkg::res_t o;
    o.event_res = ev;
    o.cur_row = 6'(r);
    o.cur_col = 6'(c);
    o.cell_open = op;
    return o;
  endfunction

  typedef struct {
    dmc_pkg::req_t rq;
    bit typed;
    dmc_pkg::res_t exp_res;
  } vec_t;

  vec_t walk_vecs [$];

  function automatic void add_vec(dmc_pkg::req_t rq, bit typed, dmc_pkg::res_t exp_res);
    vec_t v;
    v.rq = rq;
    v.typed = typed;
    v.exp_res = exp_res;
    walk_vecs.insert(walk_vecs.size(), v);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", res_o);
      end else begin
        dmc_pkg::res_t e;
        e = result_q.pop_front();
        if (res_o !== e) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", e, res_o);
        end
      end
    end
  end

  // result side stalls, with one long hold-off
  always @(negedge clk_i) begin
    if (!hold_done && n_accepted == 600) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      res_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= !quiet_now() && $urandom_range(99) < IdlePct;
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (res_valid_o && !res_stall_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int sizes [6];
    int steps, ch;
    dmc_pkg::req_t rq;
    sizes = '{3, 64, 127, 5, 9, 13};
    rows_cfg = 63;
    cols_cfg = 63;
    path_depth = 0;
    walk_row = 0;
    walk_col = 0;
    foreach (wall_bits[i]) wall_bits[i] = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_vec(mk(dmc_pkg::CmdStep, 0, 0, 0), 1, mr(dmc_pkg::EvFinished, 0, 0, 0));
    add_vec(mk(dmc_pkg::CmdRead, 63, 63, 3), 1, mr(dmc_pkg::EvRead, 0, 0, 0));
    add_vec(mk(CmdUnused, 63, 63, 3), 1, mr(dmc_pkg::EvRejected, 0, 0, 0));
    add_vec(mk(dmc_pkg::CmdStart, 63, 5, 0), 1, mr(dmc_pkg::EvRejected, 0, 0, 0));
    add_vec(mk(dmc_pkg::CmdStart, 5, 63, 0), 1, mr(dmc_pkg::EvRejected, 0, 0, 0));
    add_vec(mk(dmc_pkg::CmdStart, 0, 0, 0), 1, mr(dmc_pkg::EvStarted, 0, 0, 0));
    add_vec(mk(dmc_pkg::CmdStep, 0, 0, 3), 1, mr(dmc_pkg::EvFinished, 0, 0, 0));
    add_vec(mk(dmc_pkg::CmdStart, 62, 62, 0), 1, mr(dmc_pkg::EvStarted, 62, 62, 0));
    add_vec(mk(dmc_pkg::CmdRead, 62, 62, 0), 1, mr(dmc_pkg::EvRead, 62, 62, 1));
    add_vec(mk(dmc_pkg::CmdStart, 2, 2, 0), 1, mr(dmc_pkg::EvStarted, 2, 2, 0));
    add_vec(mk(dmc_pkg::CmdStep, 0, 0, 0), 0, '0);
    add_vec(mk(dmc_pkg::CmdStart, 1, 1, 0), 1, mr(dmc_pkg::EvStarted, 1, 1, 0));
    add_vec(mk(dmc_pkg::CmdRead, 1, 1, 0), 1, mr(dmc_pkg::EvRead, 1, 1, 1));
    add_vec(mk(dmc_pkg::CmdRead, 0, 1, 0), 1, mr(dmc_pkg::EvRead, 1, 1, 0));
    for (int i = 0; i < 4; i++) add_vec(mk(dmc_pkg::CmdStep, 0, 0, i), 0, '0);
    add_vec(mk(dmc_pkg::CmdRead, 1, 2, 0), 0, '0);
    add_vec(mk(dmc_pkg::CmdRead, 2, 1, 0), 0, '0);
    add_vec(mk(dmc_pkg::CmdRead, 0, 63, 0), 0, '0);
    foreach (walk_vecs[i]) send_req(walk_vecs[i].rq, walk_vecs[i].typed, walk_vecs[i].exp_res);
    drain();

    for (int ph = 0; n_accepted < TargetItems; ph++) begin
      write_cfg(dmc_pkg::CfgGridRows, ph < 6 ? sizes[ph] : $urandom_range(3, 21));
      write_cfg(dmc_pkg::CfgGridCols, ph < 6 ? sizes[5 - ph] : $urandom_range(3, 21));
      if ($urandom_range(9) == 0)
        send_req(mk(dmc_pkg::CmdStart, $urandom_range(63), $urandom_range(63), $urandom),
                 0, '0);
      send_req(mk(dmc_pkg::CmdStart, 2 * $urandom_range((rows_eff() - 2) / 2) + 1,
                  2 * $urandom_range((cols_eff() - 2) / 2) + 1, $urandom), 0, '0);
      steps = 0;
      while (path_depth > 0 && steps < 400 && n_accepted < TargetItems) begin
        ch = $urandom_range(99);
        if (ch < 75)
          rq = mk(dmc_pkg::CmdStep, $urandom_range(63), $urandom_range(63), $urandom);
        else if (ch < 95)
          rq = mk(dmc_pkg::CmdRead, $urandom_range(63), $urandom_range(63), $urandom);
        else if (ch < 98)
          rq = mk(CmdUnused, $urandom_range(63), $urandom_range(63), $urandom);
        else
          rq = mk(dmc_pkg::CmdStart, $urandom_range(63), $urandom_range(63), $urandom);
        send_req(rq, 0, '0);
        steps++;
      end
      send_req(mk(dmc_pkg::CmdStep, 0, 0, $urandom), 0, '0);
      drain();
    end

    @(negedge clk_i);
    req_valid_i <= 1'b0;
    wait (result_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
